/* sv/ithp_pkg.sv */
// Package for the IPv4 transport header parser: shared constants, status codes
// and the frame summary record passed from the capture front end to the judge.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ithp_pkg;

    // Default cap on the bytes of one frame that are counted and examined.
    localparam int unsigned MAX_FRAME_BYTES_DEF = 2048;

    // Number of frame summaries that may wait between front end and back end.
    localparam int unsigned SUMMARY_DEPTH = 2;

    localparam logic [7:0]  ETH_HDR_BYTES  = 8'd14;
    localparam logic [7:0]  IP_MIN_BYTES   = 8'd20;
    localparam logic [7:0]  TCP_MIN_BYTES  = 8'd20;
    localparam logic [7:0]  UDP_HDR_BYTES  = 8'd8;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    // Link type register values.
    localparam logic LINK_ETHERNET = 1'b0;
    localparam logic LINK_RAW_IP   = 1'b1;

    // Result status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TRUNCATED = 3'd1;
    localparam logic [2:0] ST_NOT_IPV4  = 3'd2;
    localparam logic [2:0] ST_IP_VER    = 3'd3;
    localparam logic [2:0] ST_BAD_IHL   = 3'd4;
    localparam logic [2:0] ST_BAD_TCPOFF = 3'd5;
    localparam logic [2:0] ST_OTHER_PROTO = 3'd6;

    // Header fields captured over one frame, plus the framing at its end.
    typedef struct packed {
        logic        link_type;
        logic [15:0] ether_kind;
        logic [7:0]  version_ihl;
        logic [15:0] total_length;
        logic [7:0]  protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [15:0] tcp_off_udp_len;
    } t_hdr;

endpackage : ithp_pkg

`default_nettype wire

/* sv/ipv4_transport_header_parser.sv */
// Top level of the IPv4 TCP/UDP header parser: front end, summary queue and
// judge back end. Depends on ithp_pkg, ithp_front, ithp_fifo and ithp_back.
//
// The parser takes one captured frame as a byte stream, one byte per transfer,
// with i_last_byte marking the final byte, and gives exactly one result per
// frame: a status, the protocol, both IPv4 addresses, both ports and the
// payload size (TCP: total length minus both header lengths; UDP: UDP length
// minus eight; both wrap to 16 bits). When the status is not ok, all other
// result fields are zero. The input side accepts one byte every cycle for as
// long as the summary queue has room; the queue holds two finished frames and
// is drained by the back end at one frame per cycle while results are popped,
// so a steady stream of frames, even of one-byte frames, runs at one byte per
// cycle when results are popped as they appear. The result of a frame reaches
// the output ports through the summary queue and the output register: the
// summary enters the queue at the edge that transfers its last byte, and the
// back end judges it into the output register once that register is free. Only the first
// MAX_FRAME_BYTES bytes of a frame are counted and examined; later bytes
// are accepted and ignored. The link type register (0 Ethernet, 1 raw IP) is
// written through i_cfg_wr_en and i_cfg_wr_data and takes effect on the next
// byte; each byte is placed by the framing in force when it arrives, and the
// end-of-frame checks use the framing in force at the last byte.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_transport_header_parser #(
    parameter int unsigned MAX_FRAME_BYTES = ithp_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_wr_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    input  wire logic        pop,
    output logic             empty,
    output logic [2:0]       o_status,
    output logic             o_is_udp,
    output logic [31:0]      o_source_address,
    output logic [31:0]      o_destination_address,
    output logic [15:0]      o_source_port,
    output logic [15:0]      o_destination_port,
    output logic [15:0]      o_payload_size
);

    import ithp_pkg::*;

    // Byte count of a frame runs up to and includes MAX_FRAME_BYTES.
    localparam int unsigned LEN_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int unsigned SUM_W = $bits(t_hdr) + LEN_W;

    t_hdr             front_hdr;
    logic [LEN_W-1:0] front_len;
    logic             front_push;
    logic             byte_xfer;
    logic [SUM_W-1:0] q_wr_data;
    logic [SUM_W-1:0] q_rd_data;
    logic             q_full;
    logic             q_empty;
    logic             back_take;
    t_hdr             back_hdr;
    logic [LEN_W-1:0] back_len;

    // Bytes stall only while the queue is full, so a last byte always finds room.
    assign full      = q_full;
    assign byte_xfer = push && !q_full;

    ithp_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .LEN_W           (LEN_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_byte_valid  (byte_xfer),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .o_hdr         (front_hdr),
        .o_len         (front_len),
        .o_push        (front_push)
    );

    assign q_wr_data = {front_len, front_hdr};

    ithp_fifo #(
        .WIDTH (SUM_W),
        .DEPTH (SUMMARY_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (front_push),
        .i_wr_data (q_wr_data),
        .i_rd      (back_take),
        .o_rd_data (q_rd_data),
        .o_full    (q_full),
        .o_empty   (q_empty)
    );

    assign back_len = q_rd_data[SUM_W-1 -: LEN_W];
    assign back_hdr = q_rd_data[$bits(t_hdr)-1:0];

    ithp_back #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .LEN_W           (LEN_W)
    ) u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_hdr                 (back_hdr),
        .i_len                 (back_len),
        .i_avail               (!q_empty),
        .o_take                (back_take),
        .i_pop                 (pop),
        .o_empty               (empty),
        .o_status              (o_status),
        .o_is_udp              (o_is_udp),
        .o_source_address      (o_source_address),
        .o_destination_address (o_destination_address),
        .o_source_port         (o_source_port),
        .o_destination_port    (o_destination_port),
        .o_payload_size        (o_payload_size)
    );

endmodule : ipv4_transport_header_parser

`default_nettype wire

/* sv/ithp_fifo.sv */
// Small register-based queue that holds frame summaries between the capture
// front end and the judge back end. Generic width and depth; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ithp_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd,
    output logic      [WIDTH-1:0] o_rd_data,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_wr, do_rd;

    assign o_full    = (r_count == FULL_CNT);
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rptr];
    assign do_wr     = i_wr && !o_full;
    assign do_rd     = i_rd && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_wr) begin
            n_wptr = (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
        end
        if (do_rd) begin
            n_rptr = (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wr_data;
        end
    end

endmodule : ithp_fifo

`default_nettype wire

/* sv/ithp_front.sv */
// Capture front end: counts the bytes of a frame, picks header fields out of
// the stream and hands a summary to the queue at the last byte. Uses ithp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ithp_front #(
    parameter int unsigned MAX_FRAME_BYTES = 2048,
    parameter int unsigned LEN_W = $clog2(MAX_FRAME_BYTES + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic              i_cfg_wr_data,
    input  wire logic              i_byte_valid,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_last_byte,
    output ithp_pkg::t_hdr         o_hdr,
    output logic       [LEN_W-1:0] o_len,
    output logic                   o_push
);

    import ithp_pkg::*;

    localparam logic [LEN_W-1:0] MAX_POS = LEN_W'(MAX_FRAME_BYTES);

    logic             r_link;
    logic [LEN_W-1:0] r_pos, n_pos;
    t_hdr             r_hdr, n_hdr;
    logic [7:0]       ipo;
    logic [7:0]       tpo;
    logic [LEN_W-1:0] p;

    // Offsets are below 128, which fits the position width whenever MAX_FRAME_BYTES is at least 64.
    function automatic logic [LEN_W-1:0] at(input logic [7:0] base, input logic [7:0] off);
        logic [7:0] sum;
        sum = base + off;
        return LEN_W'(sum);
    endfunction

    assign p   = r_pos;
    assign ipo = (r_link == LINK_RAW_IP) ? 8'd0 : ETH_HDR_BYTES;
    assign tpo = ipo + {2'b00, r_hdr.version_ihl[3:0], 2'b00};

    always_comb begin
        n_hdr           = r_hdr;
        n_hdr.link_type = r_link;
        n_pos           = r_pos;
        if (r_pos < MAX_POS) begin
            n_pos = r_pos + 1'b1;
            if (r_link == LINK_ETHERNET && (p == at(8'd0, 8'd12) || p == at(8'd0, 8'd13))) begin
                n_hdr.ether_kind = {r_hdr.ether_kind[7:0], i_data_byte};
            end
            if (p == at(ipo, 8'd0)) begin
                n_hdr.version_ihl = i_data_byte;
            end
            if (p == at(ipo, 8'd2) || p == at(ipo, 8'd3)) begin
                n_hdr.total_length = {r_hdr.total_length[7:0], i_data_byte};
            end
            if (p == at(ipo, 8'd9)) begin
                n_hdr.protocol = i_data_byte;
            end
            if (p >= at(ipo, 8'd12) && p <= at(ipo, 8'd15)) begin
                n_hdr.src_addr = {r_hdr.src_addr[23:0], i_data_byte};
            end
            if (p >= at(ipo, 8'd16) && p <= at(ipo, 8'd19)) begin
                n_hdr.dst_addr = {r_hdr.dst_addr[23:0], i_data_byte};
            end
            // Transport fields sit past the IP header start only; the protocol
            // seen here includes a protocol byte taken in this same cycle.
            if (p > at(ipo, 8'd0)) begin
                if (p == at(tpo, 8'd0) || p == at(tpo, 8'd1)) begin
                    n_hdr.src_port = {r_hdr.src_port[7:0], i_data_byte};
                end
                if (p == at(tpo, 8'd2) || p == at(tpo, 8'd3)) begin
                    n_hdr.dst_port = {r_hdr.dst_port[7:0], i_data_byte};
                end
                if (n_hdr.protocol == PROTO_UDP
                        && (p == at(tpo, 8'd4) || p == at(tpo, 8'd5))) begin
                    n_hdr.tcp_off_udp_len = {r_hdr.tcp_off_udp_len[7:0], i_data_byte};
                end
                if (n_hdr.protocol == PROTO_TCP && p == at(tpo, 8'd12)) begin
                    n_hdr.tcp_off_udp_len = {8'h00, i_data_byte};
                end
            end
        end
    end

    assign o_hdr  = n_hdr;
    assign o_len  = n_pos;
    assign o_push = i_byte_valid && i_last_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= LINK_ETHERNET;
            r_pos  <= '0;
            r_hdr  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_link <= i_cfg_wr_data;
            end
            if (i_byte_valid) begin
                if (i_last_byte) begin
                    r_pos <= '0;
                    r_hdr <= '0;
                end else begin
                    r_pos <= n_pos;
                    r_hdr <= n_hdr;
                end
            end
        end
    end

endmodule : ithp_front

`default_nettype wire

/* sv/ithp_back.sv */
// Judge back end: takes a frame summary from the queue, decides the status and
// payload size, and holds the result in the output register. Uses ithp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ithp_back #(
    parameter int unsigned MAX_FRAME_BYTES = 2048,
    parameter int unsigned LEN_W = $clog2(MAX_FRAME_BYTES + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ithp_pkg::t_hdr    i_hdr,
    input  wire logic [LEN_W-1:0]  i_len,
    input  wire logic              i_avail,
    output logic                   o_take,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output logic       [2:0]       o_status,
    output logic                   o_is_udp,
    output logic       [31:0]      o_source_address,
    output logic       [31:0]      o_destination_address,
    output logic       [15:0]      o_source_port,
    output logic       [15:0]      o_destination_port,
    output logic       [15:0]      o_payload_size
);

    import ithp_pkg::*;

    logic        r_valid;
    logic [2:0]  status;
    logic        is_udp;
    logic [15:0] payload;
    logic [7:0]  ipo;
    logic [7:0]  ihl_bytes;
    logic [7:0]  off_bytes;

    function automatic logic [LEN_W-1:0] lim(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] sum;
        sum = a + b;
        return LEN_W'(sum);
    endfunction

    assign ipo       = (i_hdr.link_type == LINK_RAW_IP) ? 8'd0 : ETH_HDR_BYTES;
    assign ihl_bytes = {2'b00, i_hdr.version_ihl[3:0], 2'b00};
    assign off_bytes = {2'b00, i_hdr.tcp_off_udp_len[7:4], 2'b00};

    always_comb begin
        status  = ST_OK;
        is_udp  = 1'b0;
        payload = '0;
        if (i_hdr.link_type == LINK_ETHERNET && i_len < lim(ETH_HDR_BYTES, 8'd0)) begin
            status = ST_TRUNCATED;
        end else if (i_hdr.link_type == LINK_ETHERNET && i_hdr.ether_kind != ETHERTYPE_IPV4) begin
            status = ST_NOT_IPV4;
        end else if (i_len < lim(ipo, IP_MIN_BYTES)) begin
            status = ST_TRUNCATED;
        end else if (i_hdr.version_ihl[7:4] != 4'd4) begin
            status = ST_IP_VER;
        end else if (ihl_bytes < IP_MIN_BYTES) begin
            status = ST_BAD_IHL;
        end else if (i_hdr.protocol == PROTO_TCP) begin
            if (i_len < lim(ipo, IP_MIN_BYTES + TCP_MIN_BYTES)
                    || i_len < lim(ipo, ihl_bytes + 8'd13)) begin
                status = ST_TRUNCATED;
            end else if (off_bytes < TCP_MIN_BYTES) begin
                status = ST_BAD_TCPOFF;
            end else begin
                payload = i_hdr.total_length - {8'h00, ihl_bytes} - {8'h00, off_bytes};
            end
        end else if (i_hdr.protocol == PROTO_UDP) begin
            if (i_len < lim(ipo, IP_MIN_BYTES + UDP_HDR_BYTES)
                    || i_len < lim(ipo, ihl_bytes + 8'd6)) begin
                status = ST_TRUNCATED;
            end else begin
                is_udp  = 1'b1;
                payload = i_hdr.tcp_off_udp_len - {8'h00, UDP_HDR_BYTES};
            end
        end else begin
            status = ST_OTHER_PROTO;
        end
    end

    assign o_take  = i_avail && (!r_valid || i_pop);
    assign o_empty = !r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    // Fields other than status read as zero for any frame that failed a check.
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            o_status <= status;
            if (status == ST_OK) begin
                o_is_udp              <= is_udp;
                o_source_address      <= i_hdr.src_addr;
                o_destination_address <= i_hdr.dst_addr;
                o_source_port         <= i_hdr.src_port;
                o_destination_port    <= i_hdr.dst_port;
                o_payload_size        <= payload;
            end else begin
                o_is_udp              <= 1'b0;
                o_source_address      <= '0;
                o_destination_address <= '0;
                o_source_port         <= '0;
                o_destination_port    <= '0;
                o_payload_size        <= '0;
            end
        end
    end

endmodule : ithp_back

`default_nettype wire

/* dv/ipv4_transport_header_parser_tb.sv */
// Self-checking testbench for the IPv4 TCP/UDP header parser: frames go in byte
// by byte, and each frame summary is checked against a local prediction.
// Depends on ithp_pkg and ipv4_transport_header_parser.
`timescale 1ns / 1ps

import ithp_pkg::*;

// One frame summary as it leaves the parser.
typedef struct packed {
    logic [2:0]  status;
    logic        is_udp;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] payload;
} t_summary;

// Tracks the header fields of the frame in flight, predicts the summary at
// its last byte, and checks the summaries the parser hands out, in order.
class frame_summary_board;
    bit          link;
    int unsigned pos;
    bit [15:0]   ether_kind;
    bit [7:0]    vihl;
    bit [15:0]   total_len;
    bit [7:0]    proto;
    bit [31:0]   src_addr;
    bit [31:0]   dst_addr;
    bit [15:0]   src_port;
    bit [15:0]   dst_port;
    bit [15:0]   l4_word;
    t_summary    awaited_summaries[$];
    int unsigned mismatches;

    function new();
        link       = LINK_ETHERNET;
        mismatches = 0;
        clear_frame();
    endfunction

    function void clear_frame();
        pos        = 0;
        ether_kind = '0;
        vihl       = '0;
        total_len  = '0;
        proto      = '0;
        src_addr   = '0;
        dst_addr   = '0;
        src_port   = '0;
        dst_port   = '0;
        l4_word    = '0;
    endfunction

    function int pending();
        return awaited_summaries.size();
    endfunction

    // Called for every byte transfer; the framing in force now places the byte.
    function void note_byte(bit [7:0] b, bit last);
        int unsigned ipo;
        int unsigned t;
        int unsigned ihl_bytes;
        int unsigned off_bytes;
        t_summary    want;

        ipo = (link == LINK_RAW_IP) ? 0 : ETH_HDR_BYTES;
        // The transport header start uses the IHL as it stood before this byte.
        t = ipo + 4 * vihl[3:0];
        if (pos < MAX_FRAME_BYTES_DEF) begin
            if (link == LINK_ETHERNET && (pos == 12 || pos == 13))
                ether_kind = {ether_kind[7:0], b};
            if (pos == ipo)
                vihl = b;
            if (pos == ipo + 2 || pos == ipo + 3)
                total_len = {total_len[7:0], b};
            if (pos == ipo + 9)
                proto = b;
            if (pos >= ipo + 12 && pos <= ipo + 15)
                src_addr = {src_addr[23:0], b};
            if (pos >= ipo + 16 && pos <= ipo + 19)
                dst_addr = {dst_addr[23:0], b};
            if (pos > ipo) begin
                if (pos == t || pos == t + 1)
                    src_port = {src_port[7:0], b};
                if (pos == t + 2 || pos == t + 3)
                    dst_port = {dst_port[7:0], b};
                if (proto == PROTO_UDP && (pos == t + 4 || pos == t + 5))
                    l4_word = {l4_word[7:0], b};
                if (proto == PROTO_TCP && pos == t + 12)
                    l4_word = {8'h00, b};
            end
            pos++;
        end
        if (!last)
            return;

        // Judge the frame with the framing in force at its last byte.
        want      = '0;
        ihl_bytes = 4 * vihl[3:0];
        off_bytes = 4 * l4_word[7:4];
        if (link == LINK_ETHERNET && pos < ETH_HDR_BYTES)
            want.status = ST_TRUNCATED;
        else if (link == LINK_ETHERNET && ether_kind != ETHERTYPE_IPV4)
            want.status = ST_NOT_IPV4;
        else if (pos < ipo + IP_MIN_BYTES)
            want.status = ST_TRUNCATED;
        else if (vihl[7:4] != 4'd4)
            want.status = ST_IP_VER;
        else if (ihl_bytes < IP_MIN_BYTES)
            want.status = ST_BAD_IHL;
        else if (proto == PROTO_TCP) begin
            if (pos < ipo + IP_MIN_BYTES + TCP_MIN_BYTES || pos < ipo + ihl_bytes + 13)
                want.status = ST_TRUNCATED;
            else if (off_bytes < TCP_MIN_BYTES)
                want.status = ST_BAD_TCPOFF;
            else begin
                want.status  = ST_OK;
                want.payload = total_len - 16'(ihl_bytes) - 16'(off_bytes);
            end
        end else if (proto == PROTO_UDP) begin
            if (pos < ipo + IP_MIN_BYTES + UDP_HDR_BYTES || pos < ipo + ihl_bytes + 6)
                want.status = ST_TRUNCATED;
            else begin
                want.status  = ST_OK;
                want.is_udp  = 1'b1;
                want.payload = l4_word - 16'(UDP_HDR_BYTES);
            end
        end else
            want.status = ST_OTHER_PROTO;

        if (want.status == ST_OK) begin
            want.src_addr = src_addr;
            want.dst_addr = dst_addr;
            want.src_port = src_port;
            want.dst_port = dst_port;
        end
        awaited_summaries = {awaited_summaries, want};
        clear_frame();
    endfunction

    // Called for every result transfer.
    function void check_summary(t_summary got);
        t_summary want;
        bit       stray;
        bit       bad;

        stray = (awaited_summaries.size() == 0);
        want  = '0;
        if (stray)
            bad = 1'b1;
        else begin
            want = awaited_summaries.pop_front();
            bad  = (got.status !== want.status) || (got.is_udp !== want.is_udp) ||
                   (got.src_addr !== want.src_addr) || (got.dst_addr !== want.dst_addr) ||
                   (got.src_port !== want.src_port) || (got.dst_port !== want.dst_port) ||
                   (got.payload !== want.payload);
        end
        if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
                if (stray)
                    $display("%0t: result arrived with none outstanding", $realtime);
                $display("%0t: expected st=%0d udp=%0d sa=%h da=%h sp=%h dp=%h len=%h",
                         $realtime, want.status, want.is_udp, want.src_addr,
                         want.dst_addr, want.src_port, want.dst_port, want.payload);
                $display("%0t: actual   st=%0d udp=%0d sa=%h da=%h sp=%h dp=%h len=%h",
                         $realtime, got.status, got.is_udp, got.src_addr,
                         got.dst_addr, got.src_port, got.dst_port, got.payload);
            end
        end
    endfunction
endclass

module ipv4_transport_header_parser_tb;

    // Cycles allowed for a byte to work its way through the front end before
    // the link type is rewritten, and for stray results to show up at the end.
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned DRAIN_CYCLES  = 10;
    // Generous ceiling on the whole run; a correct run needs far fewer cycles.
    localparam int unsigned CYCLE_LIMIT   = 800000;
    // Random stimulus stops once this many random bytes have been sent.
    localparam int unsigned RANDOM_BYTES  = 1600;
    // The receiver holds off once, long enough for the queue to fill up.
    localparam int unsigned HOLD_AT_RESULT = 40;
    localparam int unsigned HOLD_CYCLES    = 4000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic        i_cfg_wr_data;
    logic        push;
    logic        full;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        pop;
    logic        empty;
    logic [2:0]  o_status;
    logic        o_is_udp;
    logic [31:0] o_source_address;
    logic [31:0] o_destination_address;
    logic [15:0] o_source_port;
    logic [15:0] o_destination_port;
    logic [15:0] o_payload_size;

    frame_summary_board sb;

    // Frame under construction, and how its filler bytes are drawn:
    // 0 random, 1 all zeros, 2 all ones.
    bit [7:0]    frame_q[$];
    int unsigned fill_mode;
    // While set, the sender or receiver runs without idle cycles.
    bit          tx_quiet;
    bit          rx_quiet;
    int unsigned bytes_sent;
    int unsigned results_seen;

    ipv4_transport_header_parser u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_wr_en          (i_cfg_wr_en),
        .i_cfg_wr_data        (i_cfg_wr_data),
        .push                 (push),
        .full                 (full),
        .i_data_byte          (i_data_byte),
        .i_last_byte          (i_last_byte),
        .pop                  (pop),
        .empty                (empty),
        .o_status             (o_status),
        .o_is_udp             (o_is_udp),
        .o_source_address     (o_source_address),
        .o_destination_address(o_destination_address),
        .o_source_port        (o_source_port),
        .o_destination_port   (o_destination_port),
        .o_payload_size       (o_payload_size)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function bit [7:0] fill_byte();
        if (fill_mode == 1)
            return 8'h00;
        if (fill_mode == 2)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    // Appends one byte to the frame under construction.
    function void add_byte(bit [7:0] b);
        frame_q = {frame_q, b};
    endfunction

    // Builds a frame with the given control fields; every other header byte,
    // the addresses, ports, lengths and the payload, comes from fill_byte.
    function void make_frame(bit link, bit [15:0] etype, bit [3:0] ver, bit [3:0] ihl,
                             bit [7:0] proto, bit [3:0] off, int unsigned pay);
        bit [7:0] fb;
        frame_q.delete();
        if (link == LINK_ETHERNET) begin
            repeat (12) add_byte(fill_byte());
            add_byte(etype[15:8]);
            add_byte(etype[7:0]);
        end
        add_byte({ver, ihl});
        repeat (8) add_byte(fill_byte());
        add_byte(proto);
        repeat (10) add_byte(fill_byte());
        if (ihl > 5)
            repeat ((ihl - 5) * 4) add_byte(fill_byte());
        if (proto == PROTO_TCP) begin
            repeat (12) add_byte(fill_byte());
            fb = fill_byte();
            add_byte({off, fb[3:0]});
            repeat (7) add_byte(fill_byte());
            if (off > 5)
                repeat ((off - 5) * 4) add_byte(fill_byte());
        end else
            repeat (8) add_byte(fill_byte());
        repeat (pay) add_byte(fill_byte());
    endfunction

    // Rewrites the link type while the parser is idle: every outstanding
    // result has been transferred and the last byte has had time to settle.
    task automatic set_link(input bit v);
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.link = v;
    endtask

    // Offers frame_q[first..stop-1], one byte per transfer. push is left high
    // after a transfer, so back-to-back bytes keep it high without a glitch.
    task automatic send_bytes(input int unsigned first, input int unsigned stop,
                              input bit end_frame);
        int unsigned gap;
        bit          last;
        for (int unsigned i = first; i < stop; i++) begin
            gap  = tx_quiet ? 0 : $urandom_range(0, 18);
            last = end_frame && (i == stop - 1);
            if (gap != 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            push        <= 1'b1;
            i_data_byte <= frame_q[i];
            i_last_byte <= last;
            do
                @(posedge i_clk);
            while (full !== 1'b0);
            sb.note_byte(frame_q[i], last);
            bytes_sent++;
        end
    endtask

    // Sends the first cut bytes of the frame (0 means all of it). A nonzero
    // split flips the framing after that many bytes, in the middle of the frame.
    task automatic send_frame(input int unsigned cut, input int unsigned split);
        int unsigned n;
        n = (cut == 0 || cut > frame_q.size()) ? frame_q.size() : cut;
        if (split != 0 && split < n) begin
            send_bytes(0, split, 1'b0);
            set_link(~sb.link);
            send_bytes(split, n, 1'b1);
        end else
            send_bytes(0, n, 1'b1);
    endtask

    // Receiver: draws an idle gap before each result transfer, and once holds
    // off for a long stretch so that the parser fills up and lowers its input.
    initial begin
        t_summary    got;
        int unsigned gap;
        pop          <= 1'b0;
        results_seen = 0;
        rx_quiet     = 1'b0;
        do
            @(posedge i_clk);
        while (i_rst_n !== 1'b1);
        forever begin
            if (results_seen == HOLD_AT_RESULT) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            gap = rx_quiet ? 0 : $urandom_range(0, 18);
            if (gap != 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do
                @(posedge i_clk);
            while (empty !== 1'b0);
            got.status   = o_status;
            got.is_udp   = o_is_udp;
            got.src_addr = o_source_address;
            got.dst_addr = o_destination_address;
            got.src_port = o_source_port;
            got.dst_port = o_destination_port;
            got.payload  = o_payload_size;
            sb.check_summary(got);
            results_seen++;
            if (results_seen % 20 == 0)
                rx_quiet = ($urandom_range(0, 3) == 0);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Sender and sequencing: reset, directed frames, random frames, drain.
    initial begin
        int unsigned frames;
        int unsigned pick;
        int unsigned cut;
        int unsigned split;
        bit [15:0]   etype;
        bit [3:0]    ver;
        bit [3:0]    ihl;
        bit [3:0]    off;
        bit [7:0]    proto;

        sb = new();
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 1'b0;
        push          <= 1'b0;
        i_data_byte   <= '0;
        i_last_byte   <= 1'b0;
        fill_mode  = 0;
        tx_quiet   = 1'b0;
        bytes_sent = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Ethernet framing, well-formed TCP and UDP, the largest headers.
        set_link(LINK_ETHERNET);
        make_frame(sb.link, ETHERTYPE_IPV4, 4'd4, 4'd5, PROTO_TCP, 4'd5, 10);
        send_frame(0, 0);
        make_frame(sb.link, ETHERTYPE_IPV4, 4'd4, 4'd5, PROTO_UDP, 4'd0, 6);
        send_frame(0, 0);
        make_frame(sb.link, ETHERTYPE_IPV4, 4'd4, 4'd15, PROTO_TCP, 4'd15, 3);
        send_frame(0, 0);

        // All-ones and all-zero fields; zero lengths make the payload size wrap.
        fill_mode = 2;
        make_frame(sb.link, ETHERTYPE_IPV4, 4'd4, 4'd5, PROTO_TCP, 4'd5, 2);
        send_frame(0, 0);
        make_frame(sb.link, ETHERTYPE_IPV4, 4'd4, 4'd5, PROTO_UDP, 4'd0, 2);
        send_frame(0, 0);
        fill_mode = 1;
        make_frame(sb.link, ETHERTYPE_IPV4, 4'd4, 4'd5, PROTO_TCP, 4'd5, 2);
        send_frame(0, 0);
        make_frame(sb.link, ETHERTYPE_IPV4, 4'd4, 4'd5, PROTO_UDP, 4'd0, 2);
        send_frame(0, 0);
        fill_mode = 0;

        // Ethernet shortness on both sides of the ethertype check.
        make_frame(sb.link, ETHERTYPE_IPV4, 4'd4, 4'd5, PROTO_TCP, 4'd5, 0);
        send_frame(13, 0);
        send_frame(14, 0);
        send_frame(33, 0);
        // Wrong ethertype, IP version, IHL, TCP data offset and protocol.
        make_frame(sb.link, 16'h86DD, 4'd4, 4'd5, PROTO_TCP, 4'd5, 4);
        send_frame(0, 0);
        make_frame(sb.link, ETHERTYPE_IPV4, 4'd6, 4'd5, PROTO_TCP, 4'd5, 4);
        send_frame(0, 0);
        make_frame(sb.link, ETHERTYPE_IPV4, 4'd4, 4'd4, PROTO_TCP, 4'd5, 4);
        send_frame(0, 0);
        make_frame(sb.link, ETHERTYPE_IPV4, 4'd4, 4'd5, PROTO_TCP, 4'd4, 4);
        send_frame(0, 0);
        make_frame(sb.link, ETHERTYPE_IPV4, 4'd4, 4'd5, 8'd1, 4'd5, 4);
        send_frame(0, 0);

        // TCP and UDP shortness: one byte short of the fixed minimum, then
        // one byte short of the fields behind IP options.
        make_frame(sb.link, ETHERTYPE_IPV4, 4'd4, 4'd5, PROTO_TCP, 4'd5, 0);
        send_frame(53, 0);
        send_frame(54, 0);
        make_frame(sb.link, ETHERTYPE_IPV4, 4'd4, 4'd7, PROTO_TCP, 4'd5, 0);
        send_frame(54, 0);
        make_frame(sb.link, ETHERTYPE_IPV4, 4'd4, 4'd5, PROTO_UDP, 4'd0, 0);
        send_frame(41, 0);
        make_frame(sb.link, ETHERTYPE_IPV4, 4'd4, 4'd6, PROTO_UDP, 4'd0, 0);
        send_frame(43, 0);
        send_frame(1, 0);

        // A frame just longer than the byte cap; the bytes past it are ignored.
        tx_quiet = 1'b1;
        make_frame(sb.link, ETHERTYPE_IPV4, 4'd4, 4'd5, PROTO_TCP, 4'd5, 2000);
        send_frame(0, 0);
        tx_quiet = 1'b0;

        // Raw IP framing, then a framing change in the middle of a frame.
        set_link(LINK_RAW_IP);
        make_frame(sb.link, ETHERTYPE_IPV4, 4'd4, 4'd5, PROTO_TCP, 4'd6, 5);
        send_frame(0, 0);
        make_frame(sb.link, ETHERTYPE_IPV4, 4'd4, 4'd5, PROTO_UDP, 4'd0, 5);
        send_frame(0, 0);
        send_frame(19, 0);
        send_frame(20, 0);
        make_frame(sb.link, ETHERTYPE_IPV4, 4'd4, 4'd5, 8'd255, 4'd5, 5);
        send_frame(0, 0);
        make_frame(sb.link, ETHERTYPE_IPV4, 4'd4, 4'd5, PROTO_TCP, 4'd5, 20);
        send_frame(0, 10);

        // Random part: mostly well-formed frames with random content, some of
        // them cut short or with a broken field, the rest random bytes.
        bytes_sent = 0;
        frames     = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            if (frames % 16 == 15)
                set_link(1'($urandom_range(0, 1)));
            if (frames % 8 == 0)
                tx_quiet = ($urandom_range(0, 3) == 0);
            fill_mode = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 2) : 0;
            pick  = $urandom_range(0, 99);
            split = 0;
            if (pick < 80) begin
                etype = ($urandom_range(0, 19) == 0) ? 16'($urandom) : ETHERTYPE_IPV4;
                ver   = ($urandom_range(0, 19) == 0) ? 4'($urandom) : 4'd4;
                ihl   = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(5, 8));
                off   = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(5, 8));
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: proto = PROTO_TCP;
                    9:             proto = 8'($urandom);
                    default:       proto = PROTO_UDP;
                endcase
                make_frame(sb.link, etype, ver, ihl, proto, off, $urandom_range(0, 24));
                cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, frame_q.size())
                                                  : frame_q.size();
                if (pick < 3 && cut > 1)
                    split = $urandom_range(1, cut - 1);
            end else begin
                frame_q.delete();
                repeat ($urandom_range(1, 64)) add_byte(8'($urandom));
                cut = frame_q.size();
            end
            send_frame(cut, split);
            frames++;
        end

        // Drain: wait for every outstanding result, then a little longer so
        // that a stray extra result would still be caught.
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* files.f */
sv/ithp_pkg.sv
sv/ithp_fifo.sv
sv/ithp_front.sv
sv/ithp_back.sv
sv/ipv4_transport_header_parser.sv
dv/ipv4_transport_header_parser_tb.sv
